@@ hdl/cuat_pkg.sv @@
// shared types, constants and codes of the card identifier access table
`default_nettype none

package cuat_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int UID_BYTES_DEF   = 10;

  localparam int FUNC_W    = 2;
  localparam int LEN_W     = 4;
  localparam int LOW_W     = 64;
  localparam int HIGH_W    = 16;
  localparam int IDX_OUT_W = 5;
  localparam int CNT_OUT_W = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_FIND   = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADD,
    ST_SHIFT,
    ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic shift_init;
    logic shift;
    logic append;
    logic drop;
    logic publish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              req_bad;
    logic              scan_done;
    logic              hit;
    logic              full;
    logic              shift_done;
    logic [FUNC_W-1:0] func;
  } stat_t;

endpackage

`default_nettype wire

@@ hdl/cuat_dp.sv @@
// datapath: request registers, entry memory, scan compare, shift and result registers
`default_nettype none

module cuat_dp
  import cuat_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int UID_BYTES   = UID_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [FUNC_W-1:0]    func,
  input  wire logic [LEN_W-1:0]     uid_length,
  input  wire logic [LOW_W-1:0]     uid_low,
  input  wire logic [HIGH_W-1:0]    uid_high,
  input  wire cmd_t                 cmd,
  output stat_t                     stat,
  output logic                      ok,
  output logic [IDX_OUT_W-1:0]      match_index,
  output logic [CNT_OUT_W-1:0]      entry_count
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int KEY_W = 8 * UID_BYTES;
  localparam int ENT_W = KEY_W + LEN_W;

  logic [LOW_W+HIGH_W-1:0] uid_all;

  logic [FUNC_W-1:0]    func_r;
  logic [LEN_W-1:0]     len_r;
  logic [KEY_W-1:0]     key_r;

  logic [ENT_W-1:0]     mem [MAX_ENTRIES];
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     ptr_r;
  logic [CNT_W-1:0]     ptr_nxt;
  logic [ENT_W-1:0]     rd_data_r;
  logic [IDX_W-1:0]     rd_tag_r;
  logic                 rd_vld_r;
  logic                 rd_issue;

  logic                 hit_r;
  logic [IDX_W-1:0]     hit_idx_r;
  logic                 succ_r;
  logic                 ent_match;
  logic                 find_hit;

  logic                 ok_r;
  logic [IDX_OUT_W-1:0] match_index_r;
  logic [CNT_OUT_W-1:0] entry_count_r;

  assign uid_all = {uid_high, uid_low};

  // one memory read per cycle, for the scan or for the shift
  assign rd_issue = ((cmd.scan && !hit_r) || cmd.shift) && (ptr_r < count_r);

  // compare registered entry against the request, bytes at or above the length ignored
  always_comb begin
    ent_match = (rd_data_r[ENT_W-1:KEY_W] == len_r);
    for (int b = 0; b < UID_BYTES; b++) begin
      if ((LEN_W'(b) < len_r) && (rd_data_r[8*b +: 8] != key_r[8*b +: 8])) begin
        ent_match = 1'b0;
      end
    end
  end

  assign find_hit = (func_r == FUNC_FIND) && hit_r;

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.load) begin
      ptr_nxt = '0;
    end else if (cmd.shift_init) begin
      ptr_nxt = CNT_W'(hit_idx_r) + CNT_W'(1);
    end else if (rd_issue) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      len_r  <= uid_length;
      key_r  <= uid_all[KEY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[count_r[IDX_W-1:0]] <= {len_r, key_r};
    end else if (cmd.shift && rd_vld_r) begin
      mem[rd_tag_r - IDX_W'(1)] <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_data_r <= mem[ptr_r[IDX_W-1:0]];
      rd_tag_r  <= ptr_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && rd_vld_r && !hit_r && ent_match) begin
      hit_idx_r <= rd_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
      succ_r   <= 1'b0;
    end else begin
      ptr_r    <= ptr_nxt;
      rd_vld_r <= rd_issue;
      if (cmd.load) begin
        hit_r <= 1'b0;
      end else if (cmd.scan && rd_vld_r && ent_match) begin
        hit_r <= 1'b1;
      end
      if (cmd.load) begin
        succ_r <= 1'b0;
      end else if (cmd.append || cmd.drop) begin
        succ_r <= 1'b1;
      end
      if (cmd.append) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.drop) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      ok_r          <= succ_r | find_hit;
      match_index_r <= find_hit ? IDX_OUT_W'(hit_idx_r) : '0;
      entry_count_r <= CNT_OUT_W'(count_r);
    end
  end

  assign stat.req_bad    = (len_r > LEN_W'(UID_BYTES)) ||
                           ((func_r != FUNC_FIND) && (func_r != FUNC_ADD) &&
                            (func_r != FUNC_REMOVE));
  assign stat.scan_done  = !rd_vld_r && (hit_r || (ptr_r >= count_r));
  assign stat.hit        = hit_r;
  assign stat.full       = (count_r == CNT_W'(MAX_ENTRIES));
  assign stat.shift_done = !rd_vld_r && (ptr_r >= count_r);
  assign stat.func       = func_r;

  assign ok          = ok_r;
  assign match_index = match_index_r;
  assign entry_count = entry_count_r;

endmodule

`default_nettype wire

@@ hdl/cuat_ctrl.sv @@
// controller: request sequencing state machine and result handshake
`default_nettype none

module cuat_ctrl
  import cuat_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_tvalid_r;
  logic   out_tvalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_tready      = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.req_bad) begin
          state_nxt = ST_RESULT;
        end else begin
          cmd.scan = 1'b1;
          if (stat.scan_done) begin
            state_nxt = ST_RESULT;
            if (stat.func == FUNC_ADD && !stat.hit && !stat.full) begin
              state_nxt = ST_ADD;
            end else if (stat.func == FUNC_REMOVE && stat.hit) begin
              cmd.shift_init = 1'b1;
              state_nxt      = ST_SHIFT;
            end
          end
        end
      end
      ST_ADD: begin
        cmd.append = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_done) begin
          cmd.drop  = 1'b1;
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.publish    = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;

endmodule

`default_nettype wire

@@ hdl/card_uid_access_table.sv @@
// top level of the card identifier access table
// a rejected item goes straight to the result; find and add scan the stored entries, and
//   remove scans then shifts, one stored entry per cycle through the single read port of
//   the entry memory, for both scan and shift
// throughput: one item at a time, the next is taken once the result is registered
// reset: synchronous active low, empties the table; entry memory is not cleared
`default_nettype none

module card_uid_access_table
  import cuat_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int UID_BYTES   = UID_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input item
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,   // uid_length[3:0], uid_low[67:4], uid_high[83:68], zero
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  // result item
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // ok[0], match_index[5:1], entry_count[11:6], zero
);

  cmd_t                 cmd;
  stat_t                stat;
  logic                 ok;
  logic [IDX_OUT_W-1:0] match_index;
  logic [CNT_OUT_W-1:0] entry_count;

  // sequencing of scan, append and shift-down
  cuat_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // entry store, compare and result registers
  cuat_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .UID_BYTES   (UID_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .func        (in_tuser[FUNC_W-1:0]),
    .uid_length  (in_tdata[3:0]),
    .uid_low     (in_tdata[67:4]),
    .uid_high    (in_tdata[83:68]),
    .cmd         (cmd),
    .stat        (stat),
    .ok          (ok),
    .match_index (match_index),
    .entry_count (entry_count)
  );

  // pack result fields from the lowest bit up
  assign out_tdata = {4'd0, entry_count, match_index, ok};

endmodule

`default_nettype wire

@@ sim/card_uid_access_table_checker.sv @@
// scoreboard for the card identifier access table: predicts each result item and compares it
`timescale 1ns / 1ps

module card_uid_access_table_checker
  import cuat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [87:0] in_tdata,    // uid_length[3:0], uid_low[67:4], uid_high[83:68], zero
  input  wire logic [1:0]  in_tuser,    // func[1:0]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,   // ok[0], match_index[5:1], entry_count[11:6], zero
  output int               fail_count,
  output int               pending
);

  // packed from the highest bit down, so ok lands in bit 0 as on the port
  typedef struct packed {
    logic [CNT_OUT_W-1:0] entry_count;
    logic [IDX_OUT_W-1:0] match_index;
    logic                 ok;
  } reply_t;

  // shadow copy of the table, packed below entries_held
  logic [LOW_W-1:0]  shadow_low  [MAX_ENTRIES_DEF];
  logic [HIGH_W-1:0] shadow_high [MAX_ENTRIES_DEF];
  logic [LEN_W-1:0]  shadow_len  [MAX_ENTRIES_DEF];
  int                entries_held = 0;
  reply_t            replies_due [$];
  int                n_fail = 0;
  int                n_due = 0;

  assign fail_count = n_fail;
  assign pending    = n_due;

  function automatic logic [7:0] uid_byte(logic [LOW_W-1:0] lo, logic [HIGH_W-1:0] hi, int b);
    if (b < 8) return lo[8*b +: 8];
    return hi[8*(b-8) +: 8];
  endfunction

  // lowest entry whose length and first length bytes agree, -1 when absent
  function automatic int find_entry(logic [LEN_W-1:0] len, logic [LOW_W-1:0] lo,
                                    logic [HIGH_W-1:0] hi);
    logic same;
    for (int i = 0; i < entries_held; i++) begin
      if (shadow_len[i] == len) begin
        same = 1'b1;
        for (int b = 0; b < len; b++)
          if (uid_byte(shadow_low[i], shadow_high[i], b) != uid_byte(lo, hi, b)) same = 1'b0;
        if (same) return i;
      end
    end
    return -1;
  endfunction

  function automatic reply_t apply_request(logic [FUNC_W-1:0] func, logic [LEN_W-1:0] len,
                                           logic [LOW_W-1:0] lo, logic [HIGH_W-1:0] hi);
    reply_t r;
    int     hit;
    r = '0;
    if (len <= UID_BYTES_DEF) begin
      hit = find_entry(len, lo, hi);
      case (func)
        FUNC_FIND: begin
          if (hit >= 0) begin
            r.ok          = 1'b1;
            r.match_index = hit[IDX_OUT_W-1:0];
          end
        end
        FUNC_ADD: begin
          if (entries_held < MAX_ENTRIES_DEF && hit < 0) begin
            shadow_low[entries_held]  = lo;
            shadow_high[entries_held] = hi;
            shadow_len[entries_held]  = len;
            entries_held++;
            r.ok = 1'b1;
          end
        end
        FUNC_REMOVE: begin
          if (hit >= 0) begin
            for (int j = hit; j + 1 < entries_held; j++) begin
              shadow_low[j]  = shadow_low[j+1];
              shadow_high[j] = shadow_high[j+1];
              shadow_len[j]  = shadow_len[j+1];
            end
            entries_held--;
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.entry_count = entries_held[CNT_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      entries_held = 0;
      replies_due.delete();
      n_due = 0;
    end else begin
      // a result never belongs to the item taken at the same edge, so compare first
      if (out_tvalid && out_tready) begin : compare
        reply_t want;
        reply_t got;
        got = reply_t'(out_tdata[11:0]);
        if (replies_due.size() == 0) begin
          $error("unexpected result item %h", out_tdata);
          n_fail++;
        end else begin
          want = replies_due.pop_front();
          if (got.ok != want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, got.ok);
            n_fail++;
          end
          if (got.match_index != want.match_index) begin
            $error("match_index: expected %0d, actual %0d", want.match_index, got.match_index);
            n_fail++;
          end
          if (got.entry_count != want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
            n_fail++;
          end
        end
      end
      if (in_tvalid && in_tready)
        replies_due.push_back(apply_request(in_tuser, in_tdata[3:0], in_tdata[67:4],
                                            in_tdata[83:68]));
      n_due = replies_due.size();
    end
  end

endmodule

@@ sim/card_uid_access_table_test.sv @@
// top of the card identifier access table testbench: stimulus, idling and verdict
`timescale 1ns / 1ps

module card_uid_access_table_test;
  import cuat_pkg::*;

  // the one code that the operation enum leaves unused
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS    = 1550;
  localparam int POOL_SIZE       = 48;     // more identifiers than entries, so the table fills
  localparam int MAX_GAP         = 19;
  localparam int HOLD_AT_RESULT  = 200;    // result item at which the sink holds off
  localparam int HOLD_CYCLES     = 600;
  localparam int DRAIN_CYCLES    = 100;    // longer than the worst-case remove
  localparam int WATCHDOG_CYCLES = 1_000_000;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [LOW_W-1:0]  lo;
    logic [HIGH_W-1:0] hi;
  } uid_t;

  // operation mix of one stretch of the random part
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_EVEN,
    MIX_DRAIN
  } op_mix_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata   = '0;    // uid_length[3:0], uid_low[67:4], uid_high[83:68], zero
  logic [1:0]  in_tuser   = '0;    // func[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // ok[0], match_index[5:1], entry_count[11:6], zero

  int fail_count;
  int pending;

  // stretches with no idling, one counter per side
  int send_calm_left = 0;
  int sink_calm_left = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  card_uid_access_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  card_uid_access_table_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // idle cycles before the next item: mostly a random gap up to MAX_GAP, sometimes a run of back-to-back items
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic uid_t random_uid();
    uid_t id;
    id.len = LEN_W'($urandom_range(0, UID_BYTES_DEF));
    id.lo  = {$urandom, $urandom};
    id.hi  = HIGH_W'($urandom);
    return id;
  endfunction

  function automatic uid_t put_byte(uid_t id, int b, logic [7:0] v);
    if (b < 8) id.lo[8*b +: 8] = v;
    else id.hi[8*(b-8) +: 8] = v;
    return id;
  endfunction

  // bytes at or above the length carry no meaning, so fill them with junk
  function automatic uid_t scramble_tail(uid_t id);
    for (int b = id.len; b < UID_BYTES_DEF; b++) id = put_byte(id, b, 8'($urandom));
    return id;
  endfunction

  // one request item: idle, offer, then hold until the block takes it
  task automatic offer_request(input logic [FUNC_W-1:0] func, input uid_t id);
    int   gap;
    logic seen;
    gap = draw_wait(send_calm_left);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {4'b0, id.hi, id.lo, id.len};
    // tready is looked at mid-cycle, well clear of the edge
    do begin
      @(negedge clk);
      seen = in_tready;
      @(posedge clk);
    end while (!seen);
  endtask

  // result sink: random stalls, plus one long hold-off so the block backs up its input
  initial begin : result_sink
    int   stall;
    int   taken;
    logic seen;
    taken = 0;
    @(posedge clk);
    forever begin
      stall = draw_wait(sink_calm_left);
      if (taken == HOLD_AT_RESULT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        seen = out_tvalid;
        @(posedge clk);
      end while (!seen);
      taken++;
    end
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    uid_t             pool [POOL_SIZE];
    uid_t             id;
    uid_t             flip;
    op_mix_t          mix;
    logic [FUNC_W-1:0] func;
    int               roll;
    int               kind;
    mix = MIX_FILL;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part: empty table, zero length, full length extremes, bytes past the length,
    // rejected lengths, the unused code, duplicate add, absent remove and shifting on remove
    offer_request(FUNC_FIND,   {4'd0,  64'h0, 16'h0});                 // empty table, miss
    offer_request(FUNC_ADD,    {4'd0,  64'h0123_4567_89ab_cdef, 16'h5a5a});
    offer_request(FUNC_ADD,    {4'd0,  64'hffff_0000_ffff_0000, 16'h1234}); // duplicate
    offer_request(FUNC_FIND,   {4'd0,  64'h0, 16'h0});                 // hit at index 0
    offer_request(FUNC_ADD,    {4'd10, 64'hffff_ffff_ffff_ffff, 16'hffff});
    offer_request(FUNC_ADD,    {4'd10, 64'h0, 16'h0});
    offer_request(FUNC_ADD,    {4'd9,  64'hffff_ffff_ffff_ffff, 16'hff12});
    offer_request(FUNC_FIND,   {4'd9,  64'hffff_ffff_ffff_ffff, 16'h0012}); // byte 9 ignored
    offer_request(FUNC_FIND,   {4'd10, 64'hffff_ffff_ffff_ffff, 16'hff12}); // miss
    offer_request(FUNC_ADD,    {4'd3,  64'hdead_beef_cc56_3412, 16'hbeef});
    offer_request(FUNC_FIND,   {4'd3,  64'h0000_0000_0056_3412, 16'h0000}); // hit at index 4
    offer_request(FUNC_ADD,    {4'd11, 64'h1, 16'h1});                 // length too long
    offer_request(FUNC_FIND,   {4'd15, 64'h0, 16'h0});
    offer_request(FUNC_REMOVE, {4'd12, 64'h0, 16'h0});
    offer_request(FUNC_UNUSED, {4'd0,  64'h0, 16'h0});                 // ignored code
    offer_request(FUNC_REMOVE, {4'd10, 64'hffff_ffff_ffff_ffff, 16'hffff}); // middle entry
    offer_request(FUNC_FIND,   {4'd9,  64'hffff_ffff_ffff_ffff, 16'h0012}); // moved down
    offer_request(FUNC_REMOVE, {4'd10, 64'hffff_ffff_ffff_ffff, 16'hffff}); // now absent
    offer_request(FUNC_FIND,   {4'd8,  64'hffff_ffff_ffff_ffff, 16'h0000}); // length differs
    offer_request(FUNC_REMOVE, {4'd0,  64'h0, 16'h0});                 // head, all shift
    offer_request(FUNC_FIND,   {4'd3,  64'h0000_0000_0056_3412, 16'h0000});
    offer_request(FUNC_ADD,    {4'd1,  64'h80, 16'h0});
    offer_request(FUNC_ADD,    {4'd2,  64'h80, 16'h0});                 // same bytes, longer

    // random part: most requests reuse a pool of identifiers so finds hit, adds collide,
    // removes succeed and the table reaches full; the rest are near misses and junk
    foreach (pool[i]) pool[i] = random_uid();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) mix = op_mix_t'($urandom_range(0, 2));
      if ($urandom_range(0, 49) == 0) pool[$urandom_range(0, POOL_SIZE - 1)] = random_uid();

      roll = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:  func = roll < 70 ? FUNC_ADD : (roll < 90 ? FUNC_FIND : FUNC_REMOVE);
        MIX_DRAIN: func = roll < 60 ? FUNC_REMOVE : (roll < 85 ? FUNC_FIND : FUNC_ADD);
        default:   func = roll < 34 ? FUNC_ADD : (roll < 67 ? FUNC_FIND : FUNC_REMOVE);
      endcase

      kind = $urandom_range(0, 99);
      id   = pool[$urandom_range(0, POOL_SIZE - 1)];
      if (kind < 8) begin
        id = random_uid();
      end else if (kind < 16 && id.len != 0) begin
        // near miss: one byte inside the length differs
        flip = put_byte('0, $urandom_range(0, id.len - 1), 8'($urandom_range(1, 255)));
        id.lo ^= flip.lo;
        id.hi ^= flip.hi;
      end else if (kind < 20) begin
        id.len = LEN_W'($urandom_range(UID_BYTES_DEF + 1, 15));
      end
      if ($urandom_range(0, 1) == 1) id = scramble_tail(id);
      if (kind >= 96) func = FUNC_UNUSED;
      offer_request(func, id);
    end
    in_tvalid <= 1'b0;

    // wait for every outstanding result, then a quiet spell for stray items
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
